>>> design/vdc_pkg.sv
// Shared constants and types for the direction cost block.
package vdc_pkg;

    localparam int ROWS_PER_RUN     = 4;
    localparam int ASIN_TABLE_DEPTH = 256;

    localparam int DIR_W      = 16;
    localparam int SCORE_W    = 16;
    localparam int WEIGHT_W   = 16;
    localparam int SUM_W      = 20;
    localparam int COST_W     = 20;
    localparam int PROD_W     = 2 * DIR_W;
    localparam int DOT_W      = PROD_W + 1;
    localparam int MAG_W      = 31;
    localparam int FRAC_W     = 16;
    localparam int TERM_W     = 16;
    localparam int TAB_AW     = $clog2(ASIN_TABLE_DEPTH);
    localparam int SEARCH_CW  = (TAB_AW > 1) ? $clog2(TAB_AW) : 1;
    localparam int DIV_CW     = $clog2(FRAC_W);
    localparam int POS_W      = TAB_AW + FRAC_W + 1;
    localparam int TERM_SHIFT = $clog2(2 * ASIN_TABLE_DEPTH);
    localparam int P1_W       = SUM_W + SCORE_W;
    localparam int P2_W       = P1_W + WEIGHT_W;
    localparam int RES_SHIFT  = $clog2(ROWS_PER_RUN) + 28;
    localparam int RES_HI_W   = P2_W + 1 - RES_SHIFT;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MAG_W-1:0]    ONE_Q30      = MAG_W'(64'd1073741824);
    localparam logic signed [DOT_W-1:0] DOT_MAX  = DOT_W'(64'sd1073741824);
    localparam logic signed [DOT_W-1:0] DOT_MIN  = -DOT_MAX;
    localparam logic [TERM_W-1:0]   HALF_TERM    = TERM_W'(32768);
    localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [COST_W-1:0]   COST_MAX     = {COST_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(4096);
    localparam logic [P2_W:0]       ROUND_HALF   = (P2_W+1)'(1) << (RES_SHIFT - 1);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30_L   = 64'd1073741824;

    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic [SCORE_W-1:0] score;
        logic               missing;
        logic               last;
    } vdc_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_PREP,
        BK_DIVIDE,
        BK_ACCUM,
        BK_MUL1,
        BK_MUL2,
        BK_EMIT
    } vdc_back_state_t;

endpackage

>>> design/vdc_front.sv
// Front end: takes row transfers, forms the clamped dot product magnitude and queues it.
module vdc_front
    import vdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic signed [DIR_W-1:0] first_dir_x,
    input  logic signed [DIR_W-1:0] first_dir_y,
    input  logic signed [DIR_W-1:0] second_dir_x,
    input  logic signed [DIR_W-1:0] second_dir_y,
    input  logic [SCORE_W-1:0]      match_score,
    input  logic                    velocity_missing,
    input  logic                    row_is_last,
    output logic                    push,
    output vdc_entry_t              push_entry,
    input  logic                    queue_full
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic [SCORE_W-1:0]        score_reg;
    logic                      missing_reg;
    logic                      last_reg;
    logic                      accept;
    logic signed [DOT_W-1:0]   dot;
    logic signed [DOT_W-1:0]   dot_clamped;
    logic signed [DOT_W-1:0]   dot_abs;

    assign item_stall = valid_reg && queue_full;
    assign accept     = item_valid && !item_stall;
    assign push       = valid_reg && !queue_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_x_reg  <= first_dir_x * second_dir_x;
            prod_y_reg  <= first_dir_y * second_dir_y;
            score_reg   <= match_score;
            missing_reg <= velocity_missing;
            last_reg    <= row_is_last;
        end
    end

    always_comb
    begin
        dot = DOT_W'(prod_x_reg) + DOT_W'(prod_y_reg);
        priority if (dot > DOT_MAX)
            dot_clamped = DOT_MAX;
        else if (dot < DOT_MIN)
            dot_clamped = DOT_MIN;
        else
            dot_clamped = dot;
        dot_abs = dot_clamped[DOT_W-1] ? -dot_clamped : dot_clamped;

        push_entry.mag     = dot_abs[MAG_W-1:0];
        push_entry.score   = score_reg;
        push_entry.missing = missing_reg;
        push_entry.last    = last_reg;
    end

endmodule

>>> design/vdc_queue.sv
// Short queue of classified rows between the front end and the back end.
module vdc_queue
    import vdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  vdc_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output vdc_entry_t pop_entry
);

    vdc_entry_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_next;
    logic [QUEUE_CW-1:0]    count_reg;
    logic [QUEUE_CW-1:0]    count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> design/vdc_back.sv
// Back end: arcsine by table search and serial divide, run accumulation and weighted result.
module vdc_back
    import vdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                weight_wr_en,
    input  logic [WEIGHT_W-1:0] weight_wr_data,
    input  logic                empty,
    input  vdc_entry_t          pop_entry,
    output logic                pop,
    output logic                cost_valid,
    input  logic                cost_stall,
    output logic [COST_W-1:0]   angle_cost
);

    vdc_back_state_t        state_reg;
    vdc_back_state_t        state_next;

    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic                   missing_reg;
    logic                   missing_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [WEIGHT_W-1:0]    weight_reg;
    logic [WEIGHT_W-1:0]    weight_next;

    vdc_entry_t             row_reg;
    vdc_entry_t             row_next;
    logic                   full_reg;
    logic                   full_next;
    logic [TAB_AW-1:0]      lo_reg;
    logic [TAB_AW-1:0]      lo_next;
    logic [SEARCH_CW-1:0]   bit_reg;
    logic [SEARCH_CW-1:0]   bit_next;
    logic [MAG_W-1:0]       s_lo_reg;
    logic [MAG_W-1:0]       s_lo_next;
    logic [MAG_W-1:0]       den_reg;
    logic [MAG_W-1:0]       den_next;
    logic [MAG_W-1:0]       rem_reg;
    logic [MAG_W-1:0]       rem_next;
    logic [FRAC_W-1:0]      quo_reg;
    logic [FRAC_W-1:0]      quo_next;
    logic [DIV_CW-1:0]      div_cnt_reg;
    logic [DIV_CW-1:0]      div_cnt_next;
    logic [P1_W-1:0]        p1_reg;
    logic [P1_W-1:0]        p1_next;
    logic [P2_W-1:0]        p2_reg;
    logic [P2_W-1:0]        p2_next;
    logic [COST_W-1:0]      cost_reg;
    logic [COST_W-1:0]      cost_next;

    logic [MAG_W-1:0]       sine_rom [ASIN_TABLE_DEPTH];
    logic [TAB_AW-1:0]      cand;
    logic [MAG_W-1:0]       s_cand;
    logic [TAB_AW-1:0]      hi_idx;
    logic [MAG_W-1:0]       s_hi;
    logic [MAG_W:0]         rem_shift;
    logic                   rem_ge;
    logic [POS_W-1:0]       term_pos;
    logic [TERM_W-1:0]      term;
    logic [SUM_W:0]         sum_wide;
    logic [P2_W:0]          res_round;
    logic [RES_HI_W-1:0]    res_hi;
    logic [COST_W-1:0]      res_sat;
    logic                   out_free;

    // sin(pi/2 * g / depth) in Q1.30, truncating Taylor series; the point past the top entry is ONE_Q30
    for (genvar g = 0; g < ASIN_TABLE_DEPTH; g++)
    begin : g_sine
        localparam longint unsigned ANG = (HALF_PI_Q30 * g) / ASIN_TABLE_DEPTH;
        localparam longint unsigned SQ  = (ANG * ANG) >> 30;
        localparam longint unsigned T1  = ((ANG * SQ) >> 30) / 6;
        localparam longint unsigned T2  = ((T1 * SQ) >> 30) / 20;
        localparam longint unsigned T3  = ((T2 * SQ) >> 30) / 42;
        localparam longint unsigned T4  = ((T3 * SQ) >> 30) / 72;
        localparam longint unsigned T5  = ((T4 * SQ) >> 30) / 110;
        localparam longint unsigned T6  = ((T5 * SQ) >> 30) / 156;
        localparam longint unsigned T7  = ((T6 * SQ) >> 30) / 210;
        localparam longint unsigned T8  = ((T7 * SQ) >> 30) / 272;
        localparam longint unsigned T9  = ((T8 * SQ) >> 30) / 342;
        localparam longint unsigned T10 = ((T9 * SQ) >> 30) / 420;
        localparam longint unsigned T11 = ((T10 * SQ) >> 30) / 506;
        localparam longint unsigned T12 = ((T11 * SQ) >> 30) / 600;
        localparam longint ACC = longint'(ANG) - longint'(T1) + longint'(T2) - longint'(T3)
                               + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                               + longint'(T8) - longint'(T9) + longint'(T10) - longint'(T11)
                               + longint'(T12);
        localparam longint CLAMPED = (ACC < 0) ? 0
                                   : ((ACC > longint'(ONE_Q30_L)) ? longint'(ONE_Q30_L) : ACC);
        localparam logic [MAG_W-1:0] SINE_VAL = (g == 0) ? '0 : MAG_W'(CLAMPED);
        assign sine_rom[g] = SINE_VAL;
    end

    assign cand      = lo_reg | (TAB_AW'(1) << bit_reg);
    assign s_cand    = sine_rom[cand];
    assign hi_idx    = lo_reg + TAB_AW'(1);
    assign s_hi      = (lo_reg == {TAB_AW{1'b1}}) ? ONE_Q30 : sine_rom[hi_idx];
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign term_pos  = POS_W'({lo_reg, quo_reg}) + POS_W'(ASIN_TABLE_DEPTH);
    assign term      = full_reg ? HALF_TERM : TERM_W'(term_pos >> TERM_SHIFT);
    assign sum_wide  = {1'b0, sum_reg} + (SUM_W+1)'(term);
    assign res_round = {1'b0, p2_reg} + ROUND_HALF;
    assign res_hi    = res_round[P2_W:RES_SHIFT];
    assign res_sat   = (res_hi > RES_HI_W'(COST_MAX)) ? COST_MAX : res_hi[COST_W-1:0];
    assign out_free  = !out_valid_reg || !cost_stall;
    assign pop       = (state_reg == BK_IDLE) && !empty;

    assign cost_valid = out_valid_reg;
    assign angle_cost = cost_reg;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        missing_next   = missing_reg;
        out_valid_next = out_valid_reg && cost_stall;
        weight_next    = weight_wr_en ? weight_wr_data : weight_reg;
        row_next       = row_reg;
        full_next      = full_reg;
        lo_next        = lo_reg;
        bit_next       = bit_reg;
        s_lo_next      = s_lo_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        cost_next      = cost_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    row_next  = pop_entry;
                    full_next = pop_entry.mag >= ONE_Q30;
                    lo_next   = '0;
                    bit_next  = SEARCH_CW'(TAB_AW - 1);
                    s_lo_next = '0;
                    quo_next  = '0;
                    state_next = (pop_entry.mag >= ONE_Q30) ? BK_ACCUM : BK_SEARCH;
                end
            end
            BK_SEARCH:
            begin
                if (s_cand <= row_reg.mag)
                begin
                    lo_next   = cand;
                    s_lo_next = s_cand;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                    state_next = BK_PREP;
            end
            BK_PREP:
            begin
                if (s_hi > s_lo_reg)
                begin
                    den_next     = s_hi - s_lo_reg;
                    rem_next     = row_reg.mag - s_lo_reg;
                    div_cnt_next = DIV_CW'(FRAC_W - 1);
                    state_next   = BK_DIVIDE;
                end
                else
                begin
                    quo_next   = '0;
                    state_next = BK_ACCUM;
                end
            end
            BK_DIVIDE:
            begin
                rem_next     = rem_ge ? MAG_W'(rem_shift - {1'b0, den_reg})
                                      : rem_shift[MAG_W-1:0];
                quo_next     = {quo_reg[FRAC_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                    state_next = BK_ACCUM;
            end
            BK_ACCUM:
            begin
                sum_next     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                missing_next = missing_reg || row_reg.missing;
                state_next   = row_reg.last ? BK_MUL1 : BK_IDLE;
            end
            BK_MUL1:
            begin
                p1_next    = sum_reg * row_reg.score;
                state_next = BK_MUL2;
            end
            BK_MUL2:
            begin
                p2_next    = p1_reg * weight_reg;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cost_next      = missing_reg ? '0 : res_sat;
                    sum_next       = '0;
                    missing_next   = 1'b0;
                    state_next     = BK_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            missing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            weight_reg    <= WEIGHT_RESET;
        end
        else
        begin
            sum_reg       <= sum_next;
            missing_reg   <= missing_next;
            out_valid_reg <= out_valid_next;
            weight_reg    <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        full_reg    <= full_next;
        lo_reg      <= lo_next;
        bit_reg     <= bit_next;
        s_lo_reg    <= s_lo_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        cost_reg    <= cost_next;
    end

endmodule

>>> design/velocity_direction_cost.sv
// Top level of the velocity direction consistency cost block.
//
//   channel   signals                                        width  role
//   rows      item_valid/item_stall, dir x/y, score, flags   16/1   row in, one per transfer
//   result    cost_valid/cost_stall, angle_cost              20     one per run, on last row
//   weight    weight_wr_en, weight_wr_data                   16     Q4.12 cost weight
//
// In the back end a row passes through a fetch, 8 table search steps, a setup, 16 divide
// steps and an accumulate; a row at full scale goes from the fetch straight to the accumulate.
// The last row of a run adds the two multiplies and the rounding. The serial divider sets the rate.
// Reset clears the run sum, the missing flag, the queue and sets the weight to 1.0.
// A stalled result holds in the output register while the next rows are taken.
module velocity_direction_cost
    import vdc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    weight_wr_en,
    input  logic [WEIGHT_W-1:0]     weight_wr_data,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic signed [DIR_W-1:0] first_dir_x,
    input  logic signed [DIR_W-1:0] first_dir_y,
    input  logic signed [DIR_W-1:0] second_dir_x,
    input  logic signed [DIR_W-1:0] second_dir_y,
    input  logic [SCORE_W-1:0]      match_score,
    input  logic                    velocity_missing,
    input  logic                    row_is_last,
    output logic                    cost_valid,
    input  logic                    cost_stall,
    output logic [COST_W-1:0]       angle_cost
);

    logic       push;
    vdc_entry_t push_entry;
    logic       queue_full;
    logic       pop;
    logic       queue_empty;
    vdc_entry_t pop_entry;

    vdc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .first_dir_x      (first_dir_x),
        .first_dir_y      (first_dir_y),
        .second_dir_x     (second_dir_x),
        .second_dir_y     (second_dir_y),
        .match_score      (match_score),
        .velocity_missing (velocity_missing),
        .row_is_last      (row_is_last),
        .push             (push),
        .push_entry       (push_entry),
        .queue_full       (queue_full)
    );

    vdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .pop_entry  (pop_entry)
    );

    vdc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .weight_wr_en   (weight_wr_en),
        .weight_wr_data (weight_wr_data),
        .empty          (queue_empty),
        .pop_entry      (pop_entry),
        .pop            (pop),
        .cost_valid     (cost_valid),
        .cost_stall     (cost_stall),
        .angle_cost     (angle_cost)
    );

endmodule

>>> design/vdc_checker.sv
// Port-level checks for the direction cost block, bound to the top level.
module vdc_checker
    import vdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  logic              cost_valid,
    input  logic              cost_stall,
    input  logic [COST_W-1:0] angle_cost
);

    // stalled result transfer holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cost_valid && cost_stall |=> cost_valid && $stable(angle_cost))
        else $error("result changed while stalled");

    a_reset_no_result: assert property (@(posedge clk)
        !rst_n |=> !cost_valid)
        else $error("result valid during reset");

    a_reset_no_stall: assert property (@(posedge clk)
        !rst_n |=> !item_stall)
        else $error("row stall during reset");

    // front stage only fills up right after a row transfer
    a_stall_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(item_valid && !item_stall))
        else $error("row stall rose without a preceding transfer");

endmodule

bind velocity_direction_cost vdc_checker u_vdc_checker (.*);
